// ===== hw/rtl/vending_coin_change_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Vending coin change controller assertion macros
// Shared concurrent assertion helpers, clocked on clock and idle in reset.
// ----------------------------------------------------------------------------
`ifndef VENDING_COIN_CHANGE_CONTROLLER_ASSERT_SVH
`define VENDING_COIN_CHANGE_CONTROLLER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define VCC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// When the trigger holds, the outcome must hold in the next cycle.
`define VCC_ASSERT_NEXT(label, trig, outcome, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (outcome)) \
      else $error(msg);

`endif

// ===== hw/rtl/vcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Vending coin change controller package
// Field widths, reset values and the request and result payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package vcc_pkg;

   localparam int unsigned UNITS_W     = 4;
   localparam logic [UNITS_W-1:0] PRICE_RESET = 4'd10;

   typedef struct packed {
      logic clear;
      logic coin_100;
      logic coin_200;
      logic coin_500;
      logic refund_request;
      logic buy;
   } req_type;

   typedef struct packed {
      logic               deliver;
      logic               return_100;
      logic               return_200;
      logic               return_500;
      logic [UNITS_W-1:0] balance_units;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/vcc_channels.sv =====
// ----------------------------------------------------------------------------
// Vending coin change controller channels
// Valid/ready channel bundles for requests, results and the price register.
// ----------------------------------------------------------------------------
`default_nettype none

interface vcc_req_if import vcc_pkg::*; ();
   logic valid;
   logic ready;
   logic clear;
   logic coin_100;
   logic coin_200;
   logic coin_500;
   logic refund_request;
   logic buy;

   modport source (output valid, clear, coin_100, coin_200, coin_500, refund_request, buy,
                   input ready);
   modport sink   (input valid, clear, coin_100, coin_200, coin_500, refund_request, buy,
                   output ready);
endinterface

interface vcc_rsp_if import vcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               deliver;
   logic               return_100;
   logic               return_200;
   logic               return_500;
   logic [UNITS_W-1:0] balance_units;

   modport source (output valid, deliver, return_100, return_200, return_500, balance_units,
                   input ready);
   modport sink   (input valid, deliver, return_100, return_200, return_500, balance_units,
                   output ready);
endinterface

interface vcc_csr_if import vcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [UNITS_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vcc_core.sv =====
// ----------------------------------------------------------------------------
// Vending coin change controller core
// Phase, balance and change registers with the next-state logic of one request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vending_coin_change_controller_assert.svh"

module vcc_core import vcc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_accept,
   input  wire req_type            req,
   input  wire logic [UNITS_W-1:0] price,
   output rsp_type                 result
);

   typedef enum logic [2:0] {
      PH_COLLECT = 3'd0,
      PH_FULL    = 3'd1,
      PH_DELIVER = 3'd2,
      PH_PAY     = 3'd3,
      PH_Q1      = 3'd4,
      PH_Q2      = 3'd5,
      PH_Q5      = 3'd6
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [UNITS_W-1:0] balance_ff, balance_in;
   logic [UNITS_W-1:0] left_ff, left_in;
   logic               by_request_ff, by_request_in;

   logic [UNITS_W-1:0] coin_sum;
   logic [UNITS_W:0]   total;
   logic [UNITS_W:0]   excess;
   logic               refund_ok;

   assign coin_sum = {3'b000, req.coin_100} + {2'b00, req.coin_200, 1'b0}
                   + (req.coin_500 ? 4'd5 : 4'd0);
   assign total    = {1'b0, balance_ff} + {1'b0, coin_sum};
   assign excess   = total - {1'b0, price};

   // A refund is honoured only while coins are being taken, not while paying out.
   assign refund_ok = (phase_ff != PH_DELIVER) && (phase_ff != PH_PAY) &&
                      (phase_ff != PH_Q1) && (phase_ff != PH_Q2) && (phase_ff != PH_Q5);

   always_comb begin
      phase_in      = phase_ff;
      balance_in    = balance_ff;
      left_in       = left_ff;
      by_request_in = by_request_ff;
      if (req.clear) begin
         phase_in      = PH_COLLECT;
         balance_in    = '0;
         left_in       = '0;
         by_request_in = 1'b0;
      end else if (req.refund_request && refund_ok && (balance_ff != '0)) begin
         left_in       = balance_ff;
         by_request_in = 1'b1;
         phase_in      = PH_PAY;
      end else begin
         unique case (phase_ff)
            PH_FULL: begin
               if (req.buy) begin
                  balance_in = '0;
                  phase_in   = PH_DELIVER;
               end else if (coin_sum != '0) begin
                  left_in       = coin_sum;
                  by_request_in = 1'b0;
                  phase_in      = PH_PAY;
               end
            end
            PH_PAY: begin
               // Greedy payout: largest coin that still fits.
               priority if (left_ff >= 4'd5) begin
                  left_in  = left_ff - 4'd5;
                  phase_in = PH_Q5;
               end else if (left_ff >= 4'd2) begin
                  left_in  = left_ff - 4'd2;
                  phase_in = PH_Q2;
               end else if (left_ff >= 4'd1) begin
                  left_in  = left_ff - 4'd1;
                  phase_in = PH_Q1;
               end else if (by_request_ff) begin
                  balance_in    = '0;
                  by_request_in = 1'b0;
                  phase_in      = PH_COLLECT;
               end else begin
                  phase_in = PH_FULL;
               end
            end
            PH_Q1, PH_Q2, PH_Q5: begin
               phase_in = PH_PAY;
            end
            PH_DELIVER: begin
               phase_in = PH_COLLECT;
            end
            default: begin
               phase_in = PH_COLLECT;
               if (coin_sum != '0) begin
                  if (total > {1'b0, price}) begin
                     left_in       = excess[UNITS_W] ? 4'd15 : excess[UNITS_W-1:0];
                     balance_in    = price;
                     by_request_in = 1'b0;
                     phase_in      = PH_PAY;
                  end else begin
                     balance_in = total[UNITS_W-1:0];
                     if (total == {1'b0, price}) begin
                        phase_in = PH_FULL;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_COLLECT;
         balance_ff    <= '0;
         left_ff       <= '0;
         by_request_ff <= 1'b0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         balance_ff    <= balance_in;
         left_ff       <= left_in;
         by_request_ff <= by_request_in;
      end
   end

   // The result reflects the state after the request.
   assign result.deliver       = (phase_in == PH_DELIVER);
   assign result.return_100    = (phase_in == PH_Q1);
   assign result.return_200    = (phase_in == PH_Q2);
   assign result.return_500    = (phase_in == PH_Q5);
   assign result.balance_units = balance_in;

   `VCC_ASSERT_NEXT(a_clear_empties, req_accept && req.clear,
                    (balance_ff == '0) && (left_ff == '0) && (phase_ff == PH_COLLECT),
                    "clear did not empty the controller")
   `VCC_ASSERT_ALWAYS(a_change_only_paying,
                      (left_ff == '0) || (phase_ff == PH_PAY) || (phase_ff == PH_Q1) ||
                      (phase_ff == PH_Q2) || (phase_ff == PH_Q5),
                      "change pending outside the payout phases")
   `VCC_ASSERT_ALWAYS(a_deliver_empty, (phase_ff != PH_DELIVER) || (balance_ff == '0),
                      "balance left after delivery")

endmodule

`default_nettype wire

// ===== hw/rtl/vcc_out_buf.sv =====
// ----------------------------------------------------------------------------
// Vending coin change controller result buffer
// Two-entry output register with skid stage between core and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vending_coin_change_controller_assert.svh"

module vcc_out_buf import vcc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire rsp_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   logic    main_valid_ff, skid_valid_ff;
   rsp_type main_ff, skid_ff;
   logic    push, pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_ff       <= in_data;
            main_valid_ff <= 1'b1;
         end else begin
            // The result channel is stalled: park the request in the skid stage.
            skid_ff       <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   `VCC_ASSERT_ALWAYS(a_skid_behind_main, !skid_valid_ff || main_valid_ff,
                      "skid stage holds a result while the output register is empty")
   `VCC_ASSERT_NEXT(a_stall_parks, push && main_valid_ff && !out_ready, skid_valid_ff,
                    "stalled result not parked in the skid stage")
   `VCC_ASSERT_NEXT(a_idle_drains, !push && !skid_valid_ff && (pop || !main_valid_ff),
                    !main_valid_ff, "output register kept a delivered result")

endmodule

`default_nettype wire

// ===== hw/rtl/vending_coin_change_controller.sv =====
// ----------------------------------------------------------------------------
// Vending coin change controller
// Coin collection, purchase, refund and greedy change payout, one request a cycle.
// Each result is registered in the output buffer and offered on the result channel.
// Throughput: one request per cycle unless the buffer is full; single registered update.
// A two-entry output buffer keeps requests flowing while one result waits to be taken.
// Reset (synchronous): empty balance, collecting, no change pending, price of 10 units.
// ----------------------------------------------------------------------------
`default_nettype none

module vending_coin_change_controller import vcc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   vcc_req_if.sink   req_ch,
   vcc_rsp_if.source rsp_ch,
   vcc_csr_if.sink   csr_ch
);

   logic [UNITS_W-1:0] price_ff;
   logic               req_accept;
   logic               buf_ready;
   req_type            req;
   rsp_type            core_result;
   rsp_type            buf_result;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         price_ff <= PRICE_RESET;
      end else if (csr_ch.valid) begin
         price_ff <= csr_ch.data;
      end
   end

   assign req.clear          = req_ch.clear;
   assign req.coin_100       = req_ch.coin_100;
   assign req.coin_200       = req_ch.coin_200;
   assign req.coin_500       = req_ch.coin_500;
   assign req.refund_request = req_ch.refund_request;
   assign req.buy            = req_ch.buy;

   assign req_ch.ready = buf_ready;
   assign req_accept   = req_ch.valid && buf_ready;

   vcc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req        (req),
      .price      (price_ff),
      .result     (core_result)
   );

   vcc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (buf_ready),
      .in_data   (core_result),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (buf_result)
   );

   assign rsp_ch.deliver       = buf_result.deliver;
   assign rsp_ch.return_100    = buf_result.return_100;
   assign rsp_ch.return_200    = buf_result.return_200;
   assign rsp_ch.return_500    = buf_result.return_500;
   assign rsp_ch.balance_units = buf_result.balance_units;

endmodule

`default_nettype wire

// ===== dv/vending_coin_change_controller_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vending coin change controller testbench
// Drives coin, refund, buy and clear requests under random idling on both
// channels, and changes the price between phases. Every result is compared
// with a request-by-request prediction of the balance and payout sequence.
// ----------------------------------------------------------------------------

module vending_coin_change_controller_test;
   import vcc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_ITEMS = 195;
   localparam int unsigned IDLE_PCT    = 26;

   typedef enum logic [2:0] {
      PH_COLLECTING = 3'd0,
      PH_FULL       = 3'd1,
      PH_DELIVERING = 3'd2,
      PH_PAYING     = 3'd3,
      PH_PULSE_100  = 3'd4,
      PH_PULSE_200  = 3'd5,
      PH_PULSE_500  = 3'd6
   } phase_type;

   class change_scoreboard_type;
      logic [UNITS_W-1:0] price;
      logic [UNITS_W-1:0] balance;
      logic [UNITS_W-1:0] refund_left;
      logic               by_request;
      phase_type          phase;
      rsp_type            expected_q[$];
      int unsigned        error_count;
      int unsigned        result_count;

      function new();
         price        = PRICE_RESET;
         error_count  = 0;
         result_count = 0;
         empty_machine();
      endfunction

      function void empty_machine();
         phase       = PH_COLLECTING;
         balance     = '0;
         refund_left = '0;
         by_request  = 1'b0;
      endfunction

      function void set_price(logic [UNITS_W-1:0] value);
         price = value;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_request(req_type r);
         int unsigned coins;
         int unsigned total;
         int unsigned excess;
         rsp_type     want;
         coins = r.coin_100 + 2 * r.coin_200 + 5 * r.coin_500;
         if (r.clear) begin
            empty_machine();
         end else if (r.refund_request && (phase == PH_COLLECTING || phase == PH_FULL)
                      && balance != 0) begin
            refund_left = balance;
            by_request  = 1'b1;
            phase       = PH_PAYING;
         end else begin
            case (phase)
               PH_FULL: begin
                  if (r.buy) begin
                     balance = '0;
                     phase   = PH_DELIVERING;
                  end else if (coins != 0) begin
                     refund_left = UNITS_W'(coins);
                     by_request  = 1'b0;
                     phase       = PH_PAYING;
                  end
               end
               PH_PAYING: begin
                  if (refund_left >= 5) begin
                     refund_left = refund_left - 5;
                     phase       = PH_PULSE_500;
                  end else if (refund_left >= 2) begin
                     refund_left = refund_left - 2;
                     phase       = PH_PULSE_200;
                  end else if (refund_left >= 1) begin
                     refund_left = refund_left - 1;
                     phase       = PH_PULSE_100;
                  end else if (by_request) begin
                     balance    = '0;
                     by_request = 1'b0;
                     phase      = PH_COLLECTING;
                  end else begin
                     phase = PH_FULL;
                  end
               end
               PH_PULSE_100, PH_PULSE_200, PH_PULSE_500: begin
                  phase = PH_PAYING;
               end
               PH_DELIVERING: begin
                  phase = PH_COLLECTING;
               end
               default: begin
                  phase = PH_COLLECTING;
                  if (coins != 0) begin
                     total = balance + coins;
                     if (total > price) begin
                        // The balance tops out at the price; the rest goes back.
                        excess      = total - price;
                        refund_left = (excess > 15) ? 4'd15 : UNITS_W'(excess);
                        balance     = price;
                        by_request  = 1'b0;
                        phase       = PH_PAYING;
                     end else begin
                        balance = UNITS_W'(total);
                        if (total == price) begin
                           phase = PH_FULL;
                        end
                     end
                  end
               end
            endcase
         end
         want.deliver       = (phase == PH_DELIVERING);
         want.return_100    = (phase == PH_PULSE_100);
         want.return_200    = (phase == PH_PULSE_200);
         want.return_500    = (phase == PH_PULSE_500);
         want.balance_units = balance;
         expected_q.push_back(want);
      endfunction

      task report_mismatch(string what);
         error_count++;
         $display("[%0t] MISMATCH result %0d: %s", $realtime, result_count, what);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         result_count++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("no result expected, got d=%b r=%b%b%b bal=%0d",
               got.deliver, got.return_500, got.return_200, got.return_100,
               got.balance_units));
         end else begin
            want = expected_q.pop_front();
            if (got.deliver !== want.deliver || got.return_100 !== want.return_100 ||
                got.return_200 !== want.return_200 || got.return_500 !== want.return_500 ||
                got.balance_units !== want.balance_units) begin
               report_mismatch($sformatf(
                  "want d=%b r500/200/100=%b%b%b bal=%0d, got d=%b r500/200/100=%b%b%b bal=%0d",
                  want.deliver, want.return_500, want.return_200, want.return_100,
                  want.balance_units, got.deliver, got.return_500, got.return_200,
                  got.return_100, got.balance_units));
            end
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   bit          steady;
   int unsigned cycle_count;

   logic [UNITS_W-1:0] price_steps [10] =
      '{4'd15, 4'd1, 4'd0, 4'd12, 4'd3, 4'd15, 4'd10, 4'd2, 4'd1, 4'd8};

   change_scoreboard_type board = new();

   vcc_req_if req_ch ();
   vcc_rsp_if rsp_ch ();
   vcc_csr_if csr_ch ();

   vending_coin_change_controller dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_result(rsp_type'{rsp_ch.deliver, rsp_ch.return_100, rsp_ch.return_200,
                                      rsp_ch.return_500, rsp_ch.balance_units});
      end
   end

   function automatic req_type make_request(logic clear, logic c100, logic c200, logic c500,
                                            logic refund, logic buy);
      req_type r;
      r.clear          = clear;
      r.coin_100       = c100;
      r.coin_200       = c200;
      r.coin_500       = c500;
      r.refund_request = refund;
      r.buy            = buy;
      return r;
   endfunction

   // Mostly single coins, buys and refunds so that the balance reaches the
   // price and change gets paid; the remainder is coin mixes, empty requests, clears and random noise.
   function automatic req_type random_request();
      req_type     r;
      logic [5:0]  bits;
      int unsigned pick;
      r    = '0;
      bits = 6'($urandom_range(63));
      pick = $urandom_range(99);
      if (pick < 50) begin
         case ($urandom_range(2))
            0:       r.coin_100 = 1'b1;
            1:       r.coin_200 = 1'b1;
            default: r.coin_500 = 1'b1;
         endcase
      end else if (pick < 58) begin
         r.coin_100 = bits[0];
         r.coin_200 = bits[1];
         r.coin_500 = bits[2];
      end else if (pick < 72) begin
         r.buy = 1'b1;
      end else if (pick < 80) begin
         r.refund_request = 1'b1;
      end else if (pick < 86) begin
         r = '0;
      end else if (pick < 88) begin
         r       = bits;
         r.clear = 1'b1;
      end else begin
         r       = bits;
         r.clear = 1'b0;
      end
      return r;
   endfunction

   task automatic send_request(input req_type r);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.clear          <= r.clear;
      req_ch.coin_100       <= r.coin_100;
      req_ch.coin_200       <= r.coin_200;
      req_ch.coin_500       <= r.coin_500;
      req_ch.refund_request <= r.refund_request;
      req_ch.buy            <= r.buy;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_price(input logic [UNITS_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      board.set_price(value);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      reset                 = 1'b1;
      steady                = 1'b0;
      cycle_count           = 0;
      req_ch.valid          = 1'b0;
      req_ch.clear          = 1'b0;
      req_ch.coin_100       = 1'b0;
      req_ch.coin_200       = 1'b0;
      req_ch.coin_500       = 1'b0;
      req_ch.refund_request = 1'b0;
      req_ch.buy            = 1'b0;
      rsp_ch.ready          = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.data           = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk at a price of 7 through collecting, overshoot, coin
      // while full, refund beating buy, payout, delivery and clear.
      write_price(4'd7);
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 1));   // buy while collecting
      send_request(make_request(0, 1, 0, 0, 1, 0));   // refund at zero balance
      send_request(make_request(0, 0, 1, 0, 0, 0));
      send_request(make_request(0, 0, 0, 1, 0, 1));   // overshoot by one unit
      send_request(make_request(0, 0, 0, 1, 0, 0));
      send_request(make_request(0, 0, 0, 0, 1, 0));
      send_request(make_request(0, 0, 0, 0, 0, 1));
      send_request(make_request(0, 0, 1, 0, 0, 0));   // coin at full is returned
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 1, 1));   // refund and buy together
      send_request(make_request(0, 1, 1, 1, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 1, 1, 1, 1, 0));   // all coins at once
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 1));   // buy at full delivers
      send_request(make_request(0, 1, 0, 0, 0, 0));
      send_request(make_request(1, 1, 1, 1, 1, 1));   // clear wins over everything

      foreach (price_steps[i]) begin
         drain_results();
         steady = (i == 4);
         write_price(price_steps[i]);
         repeat (PHASE_ITEMS) begin
            send_request(random_request());
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      if (board.error_count == 0 && board.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
